// File: rtl/mcpt_pkg.sv
// Shared types and constants of the multi-channel periodic timer.
`timescale 1ns / 1ps
`default_nettype none

package mcpt_pkg;

	localparam int CMD_W  = 2;
	localparam int CH_W   = 3;
	localparam int TIME_W = 32;
	localparam int KIND_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_OPEN  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DONE   = 2'd0,
		KIND_ERROR  = 2'd1,
		KIND_EXPIRY = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TICK,
		ST_RD,
		ST_CMP,
		ST_FINAL
	} st_t;

	// result of the shared adder and comparator
	typedef struct packed {
		logic [TIME_W-1:0] sum;
		logic              eq;
		logic              lt;
	} alu_res_t;

endpackage

`default_nettype wire

// File: rtl/mcpt_ifs.sv
// Handshake interfaces for the command, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface mcpt_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [2:0]  channel;
	logic [31:0] delay_ms;
	logic [31:0] interval_ms;

	modport source (output valid, cmd, channel, delay_ms, interval_ms, input ready);
	modport sink   (input valid, cmd, channel, delay_ms, interval_ms, output ready);
endinterface

interface mcpt_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  channel_out;
	logic [31:0] fire_time;
	logic        last;

	modport source (output valid, kind, channel_out, fire_time, last, input ready);
	modport sink   (input valid, kind, channel_out, fire_time, last, output ready);
endinterface

interface mcpt_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/mcpt_alu.sv
// Shared saturating adder with equality and less-than compare.
`timescale 1ns / 1ps
`default_nettype none

module mcpt_alu import mcpt_pkg::*; (
	input  logic [TIME_W-1:0] a,
	input  logic [TIME_W-1:0] b,
	input  logic [TIME_W-1:0] c,
	output alu_res_t          res
);

	logic [TIME_W:0] wide;

	// add with carry out, clamp to all ones on overflow
	always_comb begin
		wide    = {1'b0, a} + {1'b0, b};
		res.sum = wide[TIME_W] ? {TIME_W{1'b1}} : wide[TIME_W-1:0];
		res.eq  = (a == c);
		res.lt  = (a < c);
	end

endmodule

`default_nettype wire

// File: rtl/mcpt_table.sv
// Per-channel trigger and reload period storage with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mcpt_table import mcpt_pkg::*; #(
	parameter int NUM_CHANNELS = 8,
	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic              clk,
	input  logic              we_exp,
	input  logic              we_per,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [TIME_W-1:0] wexp,
	input  logic [TIME_W-1:0] wper,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output logic [TIME_W-1:0] rexp,
	output logic [TIME_W-1:0] rper
);

	logic [TIME_W-1:0] exp_mem [NUM_CHANNELS];
	logic [TIME_W-1:0] per_mem [NUM_CHANNELS];

	// write trigger and period
	always_ff @(posedge clk) begin
		if (we_exp) begin
			exp_mem[waddr] <= wexp;
		end
		if (we_per) begin
			per_mem[waddr] <= wper;
		end
	end

	// registered read, hold data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rexp <= exp_mem[raddr];
			rper <= per_mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/multi_channel_periodic_timer.sv
// Open, set and close pass through the execute state into the result register; one item is handled at a time.
// A tick goes from the tick state through a table read and a compare for each channel to the final
// state when the clock moves, and from the tick state straight to the final state when it is held at the cap.
// The next command is taken only once the final result of the last one has loaded.
// The sequencer is held back only while the result channel stalls.
// Reset clears the clock and the open and armed flags and sets the cap to all ones; no table clear.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_periodic_timer import mcpt_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	mcpt_cmd_if.sink    req,
	mcpt_res_if.source  rsp,
	mcpt_cfg_if.sink    cfg
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	st_t state_q, state_d;

	logic [TIME_W-1:0]       cap_q;
	logic [TIME_W-1:0]       now_q, now_d;
	logic [NUM_CHANNELS-1:0] open_q, open_d;
	logic [NUM_CHANNELS-1:0] armed_q, armed_d;
	logic [IDX_W-1:0]        idx_q, idx_d;
	logic                    pend_q, pend_d;
	logic [IDX_W-1:0]        pend_ch_q, pend_ch_d;

	cmd_t              cmd_q;
	logic [CH_W-1:0]   ch_q;
	logic [TIME_W-1:0] delay_q;
	logic [TIME_W-1:0] interval_q;

	logic              rsp_valid_q;
	kind_t             rsp_kind_q;
	logic [CH_W-1:0]   rsp_ch_q;
	logic [TIME_W-1:0] rsp_time_q;
	logic              rsp_last_q;

	logic            out_load;
	kind_t           out_kind;
	logic [CH_W-1:0] out_ch;
	logic            out_last;
	logic            out_free;

	logic              tbl_we_exp, tbl_we_per, tbl_re;
	logic [IDX_W-1:0]  tbl_waddr, tbl_raddr;
	logic [TIME_W-1:0] tbl_wexp, tbl_rexp, tbl_rper;

	logic [TIME_W-1:0] alu_a, alu_b, alu_c;
	alu_res_t          alu_res;

	logic             accept;
	logic             ch_ok;
	logic [IDX_W-1:0] ch_idx;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             fire;
	logic             stall;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.kind        = rsp_kind_q;
	assign rsp.channel_out = rsp_ch_q;
	assign rsp.fire_time   = rsp_time_q;
	assign rsp.last        = rsp_last_q;

	mcpt_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.res (alu_res)
	);

	mcpt_table #(.NUM_CHANNELS(NUM_CHANNELS)) u_table (
		.clk    (clk),
		.we_exp (tbl_we_exp),
		.we_per (tbl_we_per),
		.waddr  (tbl_waddr),
		.wexp   (tbl_wexp),
		.wper   (interval_q),
		.re     (tbl_re),
		.raddr  (tbl_raddr),
		.rexp   (tbl_rexp),
		.rper   (tbl_rper)
	);

	// decode addressed channel and find lowest free channel
	always_comb begin
		ch_ok      = 1'b0;
		free_found = 1'b0;
		free_idx   = '0;
		ch_idx     = IDX_W'(ch_q);
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if ({{(TIME_W-CH_W){1'b0}}, ch_q} == 32'(i)) begin
				ch_ok = open_q[i];
			end
		end
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// sequencer: next state, flag updates, table and result control
	always_comb begin
		state_d    = state_q;
		now_d      = now_q;
		open_d     = open_q;
		armed_d    = armed_q;
		idx_d      = idx_q;
		pend_d     = pend_q;
		pend_ch_d  = pend_ch_q;
		out_load   = 1'b0;
		out_kind   = KIND_DONE;
		out_ch     = '0;
		out_last   = 1'b1;
		tbl_we_exp = 1'b0;
		tbl_we_per = 1'b0;
		tbl_waddr  = ch_idx;
		tbl_wexp   = alu_res.sum;
		tbl_re     = 1'b0;
		tbl_raddr  = idx_q;
		alu_a      = now_q;
		alu_b      = delay_q;
		alu_c      = cap_q;
		fire       = 1'b0;
		stall      = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd_t'(req.cmd) == CMD_TICK) ? ST_TICK : ST_EXEC;
				end
			end

			ST_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					case (cmd_q)
						CMD_OPEN: begin
							if (free_found) begin
								open_d[free_idx]  = 1'b1;
								armed_d[free_idx] = 1'b0;
								out_ch            = CH_W'(free_idx);
							end else begin
								out_kind = KIND_ERROR;
							end
						end
						CMD_SET: begin
							if (!ch_ok) begin
								out_kind = KIND_ERROR;
							end else if (delay_q == '0) begin
								armed_d[ch_idx] = 1'b0;
							end else begin
								armed_d[ch_idx] = 1'b1;
								tbl_we_exp      = 1'b1;
								tbl_we_per      = 1'b1;
							end
						end
						CMD_CLOSE: begin
							if (ch_ok) begin
								open_d[ch_idx]  = 1'b0;
								armed_d[ch_idx] = 1'b0;
							end else begin
								out_kind = KIND_ERROR;
							end
						end
						default: begin
							out_kind = KIND_ERROR;
						end
					endcase
				end
			end

			ST_TICK: begin
				// advance by one unless at or above the cap
				alu_b  = {{(TIME_W-1){1'b0}}, 1'b1};
				pend_d = 1'b0;
				idx_d  = '0;
				if (alu_res.lt) begin
					now_d   = alu_res.sum;
					state_d = ST_RD;
				end else begin
					now_d   = cap_q;
					state_d = ST_FINAL;
				end
			end

			ST_RD: begin
				tbl_re  = 1'b1;
				state_d = ST_CMP;
			end

			ST_CMP: begin
				// compare trigger with clock, reload or disarm on a fire
				alu_a     = tbl_rexp;
				alu_b     = tbl_rper;
				alu_c     = now_q;
				tbl_waddr = idx_q;
				fire      = armed_q[idx_q] && alu_res.eq;
				stall     = fire && pend_q && !out_free;
				if (!stall) begin
					if (fire) begin
						if (tbl_rper != '0) begin
							tbl_we_exp = 1'b1;
						end else begin
							armed_d[idx_q] = 1'b0;
						end
						if (pend_q) begin
							out_load = 1'b1;
							out_kind = KIND_EXPIRY;
							out_ch   = CH_W'(pend_ch_q);
							out_last = 1'b0;
						end
						pend_d    = 1'b1;
						pend_ch_d = idx_q;
					end
					if (idx_q == IDX_W'(NUM_CHANNELS - 1)) begin
						state_d = ST_FINAL;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = ST_RD;
					end
				end
			end

			ST_FINAL: begin
				// emit the held expiry as the last result, or a done result
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (pend_q) begin
						out_kind = KIND_EXPIRY;
						out_ch   = CH_W'(pend_ch_q);
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= '1;
			now_q       <= '0;
			open_q      <= '0;
			armed_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.data;
			end
			now_q   <= now_d;
			open_q  <= open_d;
			armed_q <= armed_d;
			idx_q   <= idx_d;
			pend_q  <= pend_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload: command fields, held channel and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd_t'(req.cmd);
			ch_q       <= req.channel;
			delay_q    <= req.delay_ms;
			interval_q <= req.interval_ms;
		end
		pend_ch_q <= pend_ch_d;
		if (out_load) begin
			rsp_kind_q <= out_kind;
			rsp_ch_q   <= out_ch;
			rsp_time_q <= now_q;
			rsp_last_q <= out_last;
		end
	end

`ifndef ASSERT_OFF
	// a channel is never armed unless it is open
	a_armed_open: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q & ~open_q) == '0)
		else $error("armed channel is not open");

	// a transferred command leaves idle on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("command taken but sequencer still idle");

	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |-> !out_load)
		else $error("result register overwritten while stalled");

	// a result that is not the final one of a command is loaded only during the channel scan
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !out_last) |-> (state_q == ST_CMP))
		else $error("non-final result outside channel scan");
`endif

endmodule

`default_nettype wire

// File: tb/multi_channel_periodic_timer_tb.sv
// Testbench for the multi-channel periodic timer: directed and random commands.
`timescale 1ns / 1ps

typedef struct {
	mcpt_pkg::kind_t kind;
	logic [2:0]      channel;
	logic [31:0]     fire_time;
	logic            last;
} timer_event_t;

// Predict timer events from accepted commands and check the result stream against them
class timer_scoreboard;
	localparam int CHANNELS = 8;
	localparam int REPORT_LIMIT = 10;

	logic [31:0]  clock_cap;
	logic [31:0]  now_ms;
	bit           is_open [CHANNELS];
	bit           is_armed [CHANNELS];
	logic [31:0]  fire_at [CHANNELS];
	logic [31:0]  reload_len [CHANNELS];
	timer_event_t due_events [$];
	int           mismatches;

	function new();
		clock_cap = '1;
		now_ms = '0;
		mismatches = 0;
		foreach (is_open[i]) begin
			is_open[i] = 1'b0;
			is_armed[i] = 1'b0;
		end
	endfunction

	function int pending();
		return due_events.size();
	endfunction

	// Add with saturation at all ones
	function logic [31:0] sum_clamped(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	function void add_event(mcpt_pkg::kind_t kind, logic [2:0] ch, logic [31:0] t, logic last);
		timer_event_t ev;
		ev.kind = kind;
		ev.channel = ch;
		ev.fire_time = t;
		ev.last = last;
		due_events.push_back(ev);
	endfunction

	// Apply one accepted command to the timer table and queue the events it causes
	function void note_command(mcpt_pkg::cmd_t cmd, logic [2:0] ch, logic [31:0] delay,
			logic [31:0] interval);
		logic [31:0] next_ms;
		bit          moved;
		bit          claimed;
		int          fired;
		claimed = 1'b0;
		fired = 0;
		case (cmd)
			mcpt_pkg::CMD_OPEN: begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (!claimed && !is_open[i]) begin
						is_open[i] = 1'b1;
						is_armed[i] = 1'b0;
						add_event(mcpt_pkg::KIND_DONE, i[2:0], now_ms, 1'b1);
						claimed = 1'b1;
					end
				end
				if (!claimed)
					add_event(mcpt_pkg::KIND_ERROR, 3'd0, now_ms, 1'b1);
			end
			mcpt_pkg::CMD_SET: begin
				if (!is_open[ch]) begin
					add_event(mcpt_pkg::KIND_ERROR, 3'd0, now_ms, 1'b1);
				end else begin
					if (delay == '0) begin
						is_armed[ch] = 1'b0;
					end else begin
						is_armed[ch] = 1'b1;
						fire_at[ch] = sum_clamped(now_ms, delay);
						reload_len[ch] = interval;
					end
					add_event(mcpt_pkg::KIND_DONE, 3'd0, now_ms, 1'b1);
				end
			end
			mcpt_pkg::CMD_CLOSE: begin
				if (!is_open[ch]) begin
					add_event(mcpt_pkg::KIND_ERROR, 3'd0, now_ms, 1'b1);
				end else begin
					is_open[ch] = 1'b0;
					is_armed[ch] = 1'b0;
					add_event(mcpt_pkg::KIND_DONE, 3'd0, now_ms, 1'b1);
				end
			end
			default: begin
				// advance the clock, hold it at the cap, fire only on forward motion
				next_ms = sum_clamped(now_ms, 32'd1);
				if (next_ms > clock_cap)
					next_ms = clock_cap;
				moved = next_ms > now_ms;
				now_ms = next_ms;
				if (moved) begin
					for (int i = 0; i < CHANNELS; i++) begin
						if (is_armed[i] && fire_at[i] == next_ms) begin
							if (reload_len[i] != '0)
								fire_at[i] = sum_clamped(fire_at[i], reload_len[i]);
							else
								is_armed[i] = 1'b0;
							add_event(mcpt_pkg::KIND_EXPIRY, i[2:0], next_ms, 1'b0);
							fired++;
						end
					end
				end
				if (fired == 0)
					add_event(mcpt_pkg::KIND_DONE, 3'd0, next_ms, 1'b1);
				else
					due_events[due_events.size() - 1].last = 1'b1;
			end
		endcase
	endfunction

	function void report_mismatch(string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0t] result mismatch: %s", $time, what);
	endfunction

	// Compare one transferred result with the oldest outstanding event
	function void check_result(logic [1:0] kind, logic [2:0] ch, logic [31:0] t, logic last);
		timer_event_t want;
		if (due_events.size() == 0) begin
			report_mismatch($sformatf("nothing outstanding, got kind %0d channel %0d time %0d last %0d",
				kind, ch, t, last));
			return;
		end
		want = due_events.pop_front();
		if (kind !== want.kind || ch !== want.channel || t !== want.fire_time || last !== want.last)
			report_mismatch($sformatf(
				"expected kind %0d channel %0d time %0d last %0d, got kind %0d channel %0d time %0d last %0d",
				want.kind, want.channel, want.fire_time, want.last, kind, ch, t, last));
	endfunction
endclass

module multi_channel_periodic_timer_tb;
	import mcpt_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 25;

	logic clk;
	logic arst_n;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   stuck_cycles = 0;

	timer_scoreboard timer_sb = new();

	mcpt_cmd_if req_if ();
	mcpt_res_if rsp_if ();
	mcpt_cfg_if cfg_if ();

	multi_channel_periodic_timer #(
		.NUM_CHANNELS(8)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Track transfers on every channel and feed the scoreboard
	always @(posedge clk) begin
		if (req_if.valid && req_if.ready)
			timer_sb.note_command(cmd_t'(req_if.cmd), req_if.channel, req_if.delay_ms,
				req_if.interval_ms);
		if (rsp_if.valid && rsp_if.ready)
			timer_sb.check_result(rsp_if.kind, rsp_if.channel_out, rsp_if.fire_time, rsp_if.last);
		if (cfg_if.valid && cfg_if.ready)
			timer_sb.clock_cap = cfg_if.data;
	end

	// Count cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		wait (stuck_cycles >= STALL_LIMIT);
		$display("** multi_channel_periodic_timer: FAILED **");
		$finish;
	end

	// Offer one command, idling first at random, and hold it until transferred
	task automatic send_command(cmd_t cmd, logic [2:0] ch, logic [31:0] delay,
			logic [31:0] interval);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.cmd <= cmd;
		req_if.channel <= ch;
		req_if.delay_ms <= delay;
		req_if.interval_ms <= interval;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain_results();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (timer_sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_clock_cap(logic [31:0] cap);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= cap;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Mostly short spans that fire soon, sometimes zero, sometimes the full range
	function automatic logic [31:0] random_span(int zero_pct, int small_max);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < zero_pct)
			return '0;
		if (pick < 85)
			return $urandom_range(1, small_max);
		return $urandom();
	endfunction

	// Random traffic biased toward open channels so that timers arm and expire
	task automatic run_random(int count);
		int         pick;
		int         open_list [$];
		logic [2:0] ch;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			ch = 3'($urandom());
			open_list.delete();
			foreach (timer_sb.is_open[i])
				if (timer_sb.is_open[i])
					open_list.push_back(i);
			if (pick < 45) begin
				send_command(CMD_TICK, ch, $urandom(), $urandom());
			end else if (pick < 67) begin
				if (open_list.size() != 0 && $urandom_range(0, 99) < 85)
					ch = 3'(open_list[$urandom_range(0, open_list.size() - 1)]);
				send_command(CMD_SET, ch, random_span(10, 12), random_span(40, 10));
			end else if (pick < 82) begin
				send_command(CMD_OPEN, ch, $urandom(), $urandom());
			end else begin
				if (open_list.size() != 0 && $urandom_range(0, 99) < 70)
					ch = 3'(open_list[$urandom_range(0, open_list.size() - 1)]);
				send_command(CMD_CLOSE, ch, $urandom(), $urandom());
			end
			// pause now and then until the result channel is empty
			if (n % 37 == 36)
				drain_results();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.cmd <= CMD_OPEN;
		req_if.channel <= '0;
		req_if.delay_ms <= '0;
		req_if.interval_ms <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// set and close on channels that are not open
		send_command(CMD_SET, 3'd0, 32'd5, 32'd0);
		send_command(CMD_CLOSE, 3'd7, '0, '0);
		send_command(CMD_TICK, '0, '0, '0);
		// fill the table, then one open too many
		repeat (8) send_command(CMD_OPEN, 3'd7, '1, '1);
		send_command(CMD_OPEN, '0, '0, '0);
		// periodic and one-shot on the same trigger, saturated trigger, saturated reload
		send_command(CMD_SET, 3'd0, 32'd2, 32'd3);
		send_command(CMD_SET, 3'd1, 32'd2, 32'd0);
		send_command(CMD_SET, 3'd7, '1, '1);
		send_command(CMD_SET, 3'd2, 32'd1, '1);
		send_command(CMD_TICK, '0, '0, '0);
		send_command(CMD_TICK, '0, '0, '0);
		// disarm an idle channel and a periodic one
		send_command(CMD_SET, 3'd3, 32'd0, 32'd5);
		send_command(CMD_SET, 3'd0, 32'd0, 32'd0);
		// close and reopen: the reopened channel starts disarmed
		send_command(CMD_CLOSE, 3'd1, '0, '0);
		send_command(CMD_OPEN, '0, '0, '0);
		send_command(CMD_TICK, '0, '0, '0);
		send_command(CMD_CLOSE, 3'd7, '0, '0);
		send_command(CMD_CLOSE, 3'd2, '0, '0);
		send_command(CMD_CLOSE, 3'd2, '0, '0);

		// no idling, unlimited clock
		write_clock_cap('1);
		run_random(100);

		// sender idling, clock runs into a near cap
		send_idle_pct = 53;
		write_clock_cap(timer_sb.now_ms + 32'd40);
		run_random(100);

		// receiver stalling, cap of zero pulls the clock down
		send_idle_pct = 0;
		recv_stall_pct = 53;
		write_clock_cap('0);
		run_random(60);

		// both sides idling, small cap
		send_idle_pct = 32;
		recv_stall_pct = 32;
		write_clock_cap(32'd25);
		run_random(80);

		// random cap, mixed idling
		write_clock_cap($urandom());
		run_random(100);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (timer_sb.mismatches == 0 && timer_sb.pending() == 0)
			$display("** multi_channel_periodic_timer: PASSED **");
		else
			$display("** multi_channel_periodic_timer: FAILED **");
		$finish;
	end

endmodule
